### rtl/lpl_pkg.sv
// Shared package for the look-ahead peak limiter.
// Holds the configuration, command and status types, register codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package lpl_pkg;

    // Default sizes for the top-level parameters.
    localparam int DELAY_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths.
    localparam int THR_W   = 25;
    localparam int CEIL_W  = 27;
    localparam int COEF_W  = 24;
    localparam int DLEN_W  = 7;
    localparam int GAIN_W  = 25;
    localparam int FRAC_W  = 24;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Gain of one in Q.24.
    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << FRAC_W;

    // Restoring division yields one quotient bit per step.
    localparam int DIV_STEPS = FRAC_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Register reset values.
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(8388608);
    localparam logic [CEIL_W-1:0] CEIL_RST = CEIL_W'(33000000);
    localparam logic [COEF_W-1:0] ATK_RST  = COEF_W'(11000000);
    localparam logic [COEF_W-1:0] REL_RST  = COEF_W'(16770000);
    localparam logic [DLEN_W-1:0] DLEN_RST = DLEN_W'(48);

    // Register indexes, address bits [4:2].
    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_CEILING   = 3'd1,
        REG_ATTACK    = 3'd2,
        REG_RELEASE   = 3'd3,
        REG_DELAY_LEN = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_level;
        logic [CEIL_W-1:0] ceiling_ratio;
        logic [COEF_W-1:0] atk_smooth;
        logic [COEF_W-1:0] rel_decay;
        logic [DLEN_W-1:0] delay_length;
    } cfg_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_MAG_MUL,
        ST_ENV_UPD,
        ST_CMP,
        ST_DIV,
        ST_CEIL_MUL,
        ST_CLAMP,
        ST_OUT_MUL,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic env_mul;
        logic mag_mul;
        logic env_upd;
        logic cmp;
        logic div_step;
        logic div_last;
        logic ceil_mul;
        logic clamp;
        logic out_mul;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic over;
        logic out_free;
    } status_t;

endpackage

### rtl/lpl_if.sv
// Stream interfaces for the limiter's sample input and result output.
// Depends on lpl_pkg for the default sample width and the gain width.
`timescale 1ns / 1ps

interface lpl_in_if #(parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          in_last;

    modport source (output valid, output in_sample, output in_last, input ready);
    modport sink   (input valid, input in_sample, input in_last, output ready);
endinterface

interface lpl_out_if #(parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic [lpl_pkg::GAIN_W-1:0]    gain_now;
    logic                          out_last;

    modport source (output valid, output out_sample, output gain_now, output out_last,
                    input ready);
    modport sink   (input valid, input out_sample, input gain_now, input out_last,
                    output ready);
endinterface

### rtl/lookahead_peak_limiter.sv
// Top level of the look-ahead peak limiter: register block, controller, datapath.
// Depends on lpl_pkg, lpl_if, lpl_regs, lpl_ctrl, lpl_datapath and lpl_ram.
// A sample passes the envelope, compare, ceiling, clamp and output states, and the 24-step
// restoring divide only when the envelope is over threshold and the gain is divided out.
// A new transaction is taken only once the previous result is in the output register.
// Reset (rst_n, asynchronous, active low) restores registers, envelope and delay pointer.
`timescale 1ns / 1ps

module lookahead_peak_limiter #(
    parameter int DELAY_DEPTH = lpl_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpl_pkg::PADDR_W-1:0] paddr,
    input  logic [lpl_pkg::PDATA_W-1:0] pwdata,
    output logic [lpl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    lpl_in_if.sink                      in_chan,
    lpl_out_if.source                   out_chan
);
    import lpl_pkg::*;

    // The block works on one sample at a time. A transaction on in_chan starts the
    // sequence: the delay line is read at the write pointer and the new sample is
    // written into that entry, then the shared multiplier updates the peak envelope in
    // two products. If the envelope is over threshold, a restoring divider forms
    // threshold over envelope one quotient bit per cycle. The gain is then scaled
    // by the ceiling ratio, clamped to one, and applied to the delayed sample with
    // rounding and saturation.
    //
    // The finished result sits in an output register, so a new sample can be taken
    // while the previous result still waits on out_chan.
    //
    // The delay line is a RAM without a clearing pass: a fill count tracks the
    // prefix of entries written since reset, and any entry past it reads as zero.

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    lpl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_ready (in_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lpl_datapath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (in_chan.in_sample),
        .in_last    (in_chan.in_last),
        .out_sample (out_chan.out_sample),
        .gain_now   (out_chan.gain_now),
        .out_last   (out_chan.out_last),
        .out_valid  (out_chan.valid),
        .out_ready  (out_chan.ready)
    );

endmodule

### rtl/lpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lpl_regs.sv
// APB-style configuration register block for the limiter.
// Depends on lpl_pkg for the register codes, reset values and cfg_t.
`timescale 1ns / 1ps

module lpl_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpl_pkg::PADDR_W-1:0] paddr,
    input  logic [lpl_pkg::PDATA_W-1:0] pwdata,
    output logic [lpl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output lpl_pkg::cfg_t               cfg
);
    import lpl_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_THRESHOLD: cfg_next.threshold_level = pwdata[THR_W-1:0];
                REG_CEILING:   cfg_next.ceiling_ratio   = pwdata[CEIL_W-1:0];
                REG_ATTACK:    cfg_next.atk_smooth      = pwdata[COEF_W-1:0];
                REG_RELEASE:   cfg_next.rel_decay       = pwdata[COEF_W-1:0];
                REG_DELAY_LEN: cfg_next.delay_length    = pwdata[DLEN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_THRESHOLD: prdata = PDATA_W'(cfg_reg.threshold_level);
            REG_CEILING:   prdata = PDATA_W'(cfg_reg.ceiling_ratio);
            REG_ATTACK:    prdata = PDATA_W'(cfg_reg.atk_smooth);
            REG_RELEASE:   prdata = PDATA_W'(cfg_reg.rel_decay);
            REG_DELAY_LEN: prdata = PDATA_W'(cfg_reg.delay_length);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level <= THR_RST;
            cfg_reg.ceiling_ratio   <= CEIL_RST;
            cfg_reg.atk_smooth      <= ATK_RST;
            cfg_reg.rel_decay       <= REL_RST;
            cfg_reg.delay_length    <= DLEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/lpl_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
// Depends on lpl_pkg for state_t, cmd_t, status_t and the divider step count.
`timescale 1ns / 1ps

module lpl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpl_pkg::status_t   status,
    output lpl_pkg::cmd_t      cmd
);
    import lpl_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              div_done;

    assign div_done = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_ENV_MUL;
            ST_ENV_MUL:  state_next = ST_MAG_MUL;
            ST_MAG_MUL:  state_next = ST_ENV_UPD;
            ST_ENV_UPD:  state_next = ST_CMP;
            ST_CMP:      state_next = status.over ? ST_DIV : ST_CEIL_MUL;
            ST_DIV:      if (div_done) state_next = ST_CEIL_MUL;
            ST_CEIL_MUL: state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_OUT_MUL;
            ST_OUT_MUL:  state_next = ST_OUT;
            ST_OUT:      if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // The counter returns to zero on the last divide step.
    always_comb
    begin
        cnt_next = (state_reg == ST_DIV && !div_done) ? cnt_reg + CNT_W'(1) : '0;
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_ENV_MUL:  cmd.env_mul = 1'b1;
            ST_MAG_MUL:  cmd.mag_mul = 1'b1;
            ST_ENV_UPD:  cmd.env_upd = 1'b1;
            ST_CMP:      cmd.cmp = 1'b1;
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = div_done;
            end
            ST_CEIL_MUL: cmd.ceil_mul = 1'b1;
            ST_CLAMP:    cmd.clamp = 1'b1;
            ST_OUT_MUL:  cmd.out_mul = 1'b1;
            ST_OUT:      cmd.out_load = status.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The divider counter only runs while dividing.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (cnt_reg == '0))
        else $error("divider step counter running outside the divide state");

    // On its last step, a division always moves on to the ceiling multiply.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done) |=> (state_reg == ST_CEIL_MUL))
        else $error("divide state left at the wrong step");

    // A new sample is taken only from the idle state and starts the envelope sequence.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_ENV_MUL))
        else $error("accepted sample did not start the envelope sequence");

endmodule

### rtl/lpl_datapath.sv
// Datapath of the limiter: delay line, envelope, gain divider and output scaling.
// Depends on lpl_pkg for cfg_t, cmd_t, status_t and constants, and on lpl_ram.
`timescale 1ns / 1ps

module lpl_datapath #(
    parameter int DELAY_DEPTH = lpl_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = lpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpl_pkg::cfg_t                 cfg,
    input  lpl_pkg::cmd_t                 cmd,
    output lpl_pkg::status_t              status,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic [lpl_pkg::GAIN_W-1:0]    gain_now,
    output logic                          out_last,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import lpl_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int HW = $clog2(DELAY_DEPTH + 1);
    localparam int LW = (HW > DLEN_W) ? HW : DLEN_W;
    localparam int XW = (S > CEIL_W) ? S : CEIL_W;
    localparam int PW = XW + GAIN_W;
    localparam int NW = S + FRAC_W;
    localparam int MW = PW - FRAC_W + 1;

    localparam logic [S-1:0]  ENV_MAX  = S'(1) << (S - 1);
    localparam logic [MW-1:0] POS_MAX  = (MW'(1) << (S - 1)) - MW'(1);
    localparam logic [MW-1:0] NEG_MAX  = MW'(1) << (S - 1);
    localparam logic [PW:0]   RND_HALF = (PW + 1)'(1) << (FRAC_W - 1);

    // Control state, cleared by reset.
    logic [AW-1:0]     wptr_reg,  wptr_next;
    logic [HW-1:0]     fill_reg,  fill_next;
    logic [S-1:0]      env_reg,   env_next;
    logic              ovalid_reg, ovalid_next;

    // Payload registers.
    logic [AW-1:0]     waddr_reg,   waddr_next;
    logic [S-1:0]      x_reg,       x_next;
    logic              last_reg,    last_next;
    logic [S-1:0]      mag_reg,     mag_next;
    logic              attack_reg,  attack_next;
    logic [S-1:0]      delayed_reg, delayed_next;
    logic [PW-1:0]     prod_reg,    prod_next;
    logic [PW-1:0]     acc_reg,     acc_next;
    logic [S-1:0]      rem_reg,     rem_next;
    logic [FRAC_W-1:0] numlo_reg,   numlo_next;
    logic [FRAC_W-1:0] quo_reg,     quo_next;
    logic [GAIN_W-1:0] gain_reg,    gain_next;
    logic [S-1:0]      osample_reg, osample_next;
    logic [GAIN_W-1:0] ogain_reg,   ogain_next;
    logic              olast_reg,   olast_next;

    logic [LW-1:0]     dlen;
    logic [LW-1:0]     len_eff;
    logic [LW-1:0]     wptr_inc;
    logic [S-1:0]      in_bits;
    logic [S-1:0]      in_mag;
    logic [S-1:0]      ram_rdata;
    logic              ram_we;
    logic              rd_hit;
    logic [XW-1:0]     mul_x;
    logic [GAIN_W-1:0] mul_y;
    logic [PW-1:0]     mul_p;
    logic [PW:0]       env_sum;
    logic [NW-1:0]     num;
    logic [NW-1:0]     env_scaled;
    logic              over;
    logic [S:0]        trial;
    logic [S:0]        diff;
    logic              ge;
    logic [PW-FRAC_W-1:0] gain_hi;
    logic [S-1:0]      dmag;
    logic [PW:0]       rnd;
    logic [MW-1:0]     rmag;
    logic [MW-1:0]     rsat;
    logic              out_free;

    // Effective delay length: zero acts as one, beyond the depth acts as the depth.
    always_comb
    begin
        dlen = LW'(cfg.delay_length);
        if (dlen == '0)
        begin
            len_eff = LW'(1);
        end
        else if (dlen > LW'(DELAY_DEPTH))
        begin
            len_eff = LW'(DELAY_DEPTH);
        end
        else
        begin
            len_eff = dlen;
        end
    end

    assign wptr_inc = LW'(wptr_reg) + LW'(1);
    assign in_bits  = in_sample;
    assign in_mag   = in_bits[S-1] ? (~in_bits + S'(1)) : in_bits;

    // Entries at or beyond the fill count were never written and read as zero.
    assign rd_hit = (HW'(waddr_reg) < fill_reg);
    assign ram_we = cmd.env_mul;

    lpl_ram #(
        .WIDTH (S),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_reg),
        .wdata (x_reg),
        .re    (cmd.accept),
        .raddr (wptr_reg),
        .rdata (ram_rdata)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        if (cmd.env_mul)
        begin
            mul_x = XW'(env_reg);
            mul_y = GAIN_W'(attack_reg ? cfg.atk_smooth : cfg.rel_decay);
        end
        else if (cmd.mag_mul)
        begin
            mul_x = XW'(mag_reg);
            mul_y = UNITY - GAIN_W'(cfg.atk_smooth);
        end
        else if (cmd.ceil_mul)
        begin
            mul_x = XW'(cfg.ceiling_ratio);
            mul_y = gain_reg;
        end
        else if (cmd.out_mul)
        begin
            mul_x = XW'(dmag);
            mul_y = gain_reg;
        end
    end

    assign mul_p = mul_x * mul_y;

    assign env_sum    = {1'b0, acc_reg} + {1'b0, (attack_reg ? prod_reg : '0)};
    assign num        = {cfg.threshold_level, {(S - 1){1'b0}}};
    assign env_scaled = {env_reg, {FRAC_W{1'b0}}};
    assign over       = (env_scaled > num) && (env_reg != '0);

    assign trial = {rem_reg, numlo_reg[FRAC_W-1]};
    assign diff  = trial - {1'b0, env_reg};
    assign ge    = (trial >= {1'b0, env_reg});

    assign gain_hi = prod_reg[PW-1:FRAC_W];
    assign dmag    = delayed_reg[S-1] ? (~delayed_reg + S'(1)) : delayed_reg;

    // Round half away from zero on the magnitude, then saturate per sign.
    assign rnd  = {1'b0, prod_reg} + RND_HALF;
    assign rmag = rnd[PW:FRAC_W];

    always_comb
    begin
        if (delayed_reg[S-1])
        begin
            rsat = (rmag > NEG_MAX) ? NEG_MAX : rmag;
        end
        else
        begin
            rsat = (rmag > POS_MAX) ? POS_MAX : rmag;
        end
    end

    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        wptr_next    = wptr_reg;
        fill_next    = fill_reg;
        env_next     = env_reg;
        ovalid_next  = ovalid_reg;
        waddr_next   = waddr_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        mag_next     = mag_reg;
        attack_next  = attack_reg;
        delayed_next = delayed_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        numlo_next   = numlo_reg;
        quo_next     = quo_reg;
        gain_next    = gain_reg;
        osample_next = osample_reg;
        ogain_next   = ogain_reg;
        olast_next   = olast_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cmd.accept)
        begin
            x_next      = in_bits;
            last_next   = in_last;
            mag_next    = in_mag;
            attack_next = (in_mag > env_reg);
            waddr_next  = wptr_reg;
            wptr_next   = (wptr_inc >= len_eff) ? '0 : wptr_inc[AW-1:0];
        end

        if (cmd.env_mul)
        begin
            delayed_next = rd_hit ? ram_rdata : '0;
            if (HW'(waddr_reg) >= fill_reg)
            begin
                fill_next = HW'(waddr_reg) + HW'(1);
            end
        end

        if (cmd.env_mul || cmd.mag_mul || cmd.ceil_mul || cmd.out_mul)
        begin
            prod_next = mul_p;
        end

        if (cmd.mag_mul)
        begin
            acc_next = prod_reg;
        end

        if (cmd.env_upd)
        begin
            env_next = env_sum[FRAC_W +: S];
        end

        if (cmd.cmp)
        begin
            if (over)
            begin
                rem_next   = num[NW-1:FRAC_W];
                numlo_next = num[FRAC_W-1:0];
                quo_next   = '0;
            end
            else
            begin
                gain_next = UNITY;
            end
        end

        if (cmd.div_step)
        begin
            rem_next   = ge ? diff[S-1:0] : trial[S-1:0];
            numlo_next = {numlo_reg[FRAC_W-2:0], 1'b0};
            quo_next   = {quo_reg[FRAC_W-2:0], ge};
            if (cmd.div_last)
            begin
                gain_next = {1'b0, quo_next};
            end
        end

        if (cmd.clamp)
        begin
            gain_next = (gain_hi > (PW - FRAC_W)'(UNITY)) ? UNITY : gain_hi[GAIN_W-1:0];
        end

        if (cmd.out_load)
        begin
            ovalid_next  = 1'b1;
            osample_next = delayed_reg[S-1] ? (~rsat[S-1:0] + S'(1)) : rsat[S-1:0];
            ogain_next   = gain_reg;
            olast_next   = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg   <= '0;
            fill_reg   <= '0;
            env_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg   <= wptr_next;
            fill_reg   <= fill_next;
            env_reg    <= env_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg   <= waddr_next;
        x_reg       <= x_next;
        last_reg    <= last_next;
        mag_reg     <= mag_next;
        attack_reg  <= attack_next;
        delayed_reg <= delayed_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        numlo_reg   <= numlo_next;
        quo_reg     <= quo_next;
        gain_reg    <= gain_next;
        osample_reg <= osample_next;
        ogain_reg   <= ogain_next;
        olast_reg   <= olast_next;
    end

    assign status.over     = over;
    assign status.out_free = out_free;

    assign out_sample = osample_reg;
    assign gain_now   = ogain_reg;
    assign out_last   = olast_reg;
    assign out_valid  = ovalid_reg;

    // The envelope is a magnitude and never exceeds full scale.
    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= ENV_MAX)
        else $error("peak envelope above full scale");

    // The controller loads a result only when the output register can take it.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken result");

    // A delivered gain is clamped to one.
    a_gain_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (ogain_reg <= UNITY))
        else $error("delivered gain above one");

    // Division only runs against a nonzero envelope.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (env_reg != '0))
        else $error("gain division with a zero envelope");

    // The written prefix of the delay line only grows.
    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fill_reg >= $past(fill_reg)))
        else $error("delay fill count went backward");

endmodule
